FILE: rtl/core/wavetable_playback_engine_defines.svh
// Assertion macros for the wavetable playback engine.
`ifndef WAVETABLE_PLAYBACK_ENGINE_DEFINES_SVH
`define WAVETABLE_PLAYBACK_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define WPE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WPE_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPE_ASSERT(label, clk, rst_n, prop, msg)
`define WPE_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/wpe_pkg.sv
// ----------------------------------------------------------------------------
// wpe_pkg
// Types and constants shared by the wavetable playback engine.
// ----------------------------------------------------------------------------
package wpe_pkg;
    localparam int unsigned CLOCK_HZ    = 16000000;
    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned MAX_SHIFTS  = 8;
    localparam int unsigned N_SHIFTS    = (MAX_SHIFTS < 8) ? MAX_SHIFTS : 8;
    localparam int unsigned DEPTH_MASK  = TABLE_DEPTH - 1;
    // dividend width: CLOCK_HZ << 7 fits in 34 bits
    localparam int unsigned DW = 34;
    localparam logic [15:0] RESET_PERIOD = 16'd1136;
    localparam logic [3:0]  RESET_LOG2   = 4'd8;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_STAGE = 2'd1;
    localparam logic [1:0] FUNC_RATE  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  entry_index;
        logic signed [7:0] entry_value;
        logic        entry_last;
        logic [23:0] step_rate;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pwm_level;
        logic [15:0] timer_period;
        logic [7:0]  played_index;
    } t_out_item;

    localparam int unsigned QDEPTH = 2;
endpackage

FILE: rtl/core/wpe_front.sv
// ----------------------------------------------------------------------------
// wpe_front
// Input queue: accepts beats and drops unused func codes.
// ----------------------------------------------------------------------------
module wpe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wpe_pkg::t_in_item i_data,
    output logic              o_full,
    output logic              o_valid,
    output wpe_pkg::t_in_item o_data,
    input  logic              i_take
);
    import wpe_pkg::*;
    t_in_item   r_q [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_acc, w_keep;

    assign o_full  = (r_cnt == 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign w_acc   = i_push && !o_full;
    assign w_keep  = w_acc && (i_data.func != 2'd3);

    always_comb begin
        n_cnt = r_cnt + {1'b0, w_keep} - {1'b0, i_take && o_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_keep) r_wp <= ~r_wp;
            if (i_take && o_valid) r_rp <= ~r_rp;
        end
        if (w_keep) r_q[r_wp] <= i_data;
    end
endmodule

FILE: rtl/core/wpe_divider.sv
// ----------------------------------------------------------------------------
// wpe_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpe_divider (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [wpe_pkg::DW-1:0] i_num,
    input  logic [23:0]            i_den,
    output logic                   o_done,
    output logic [wpe_pkg::DW-1:0] o_quo
);
    import wpe_pkg::*;
    logic [DW-1:0] r_num, r_quo;
    logic [24:0]   r_rem;
    logic [23:0]   r_den;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic [24:0]   w_trial;
    logic [25:0]   w_diff;

    assign w_trial = {r_rem[23:0], r_num[DW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b0, r_den};
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'(DW - 1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_cnt <= r_cnt + 6'd1;
            if (!w_diff[25]) begin
                r_rem <= w_diff[24:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: rtl/core/wpe_back.sv
// ----------------------------------------------------------------------------
// wpe_back
// Executes ticks, stage writes and rate searches; holds tables and state.
// ----------------------------------------------------------------------------
`include "wavetable_playback_engine_defines.svh"
module wpe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    input  logic               i_valid,
    input  wpe_pkg::t_in_item  i_data,
    output logic               o_take,
    output logic               o_empty,
    output wpe_pkg::t_out_item o_data,
    input  logic               i_pop
);
    import wpe_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_RATE  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_CLR   = 7'b1000000
    } t_state;

    t_state      r_st;
    t_in_item    r_it;
    logic [7:0]  r_play [TABLE_DEPTH];
    logic [7:0]  r_stage [TABLE_DEPTH];
    logic [7:0]  r_ps_rd, r_st_rd;
    logic [7:0]  r_clr;
    logic [7:0]  r_idx, r_astep, r_pstep, r_cstep;
    logic [15:0] r_pper, r_aper;
    logic        r_upd, r_armed, r_run, r_outv, r_use_st;
    logic [23:0] r_last;
    logic [3:0]  r_log2;
    logic [2:0]  r_sh;
    logic [7:0]  r_ridx;
    logic [DW-1:0] r_q;
    t_out_item   r_out, r_pend;
    logic        w_start, w_done, w_hit, w_out_move;
    logic [DW-1:0] w_quo;
    logic [7:0]  w_mask, w_rem_mask, w_samp;
    logic [3:0]  w_l;
    logic        w_run, w_upd_now;
    logic [7:0]  w_step;

    wpe_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(DW'(CLOCK_HZ) << r_sh), .i_den(r_it.step_rate),
        .o_done(w_done), .o_quo(w_quo)
    );

    assign o_take  = (r_st == S_IDLE) && i_valid;
    assign o_empty = !r_outv;
    assign o_data  = r_out;
    assign w_start = (r_st == S_DIV);
    assign w_hit   = w_quo > DW'(255);
    assign w_l     = (r_log2 > 4'd8) ? 4'd8 : r_log2;
    assign w_mask  = 8'(((9'd1 << w_l) - 9'd1) & 9'(DEPTH_MASK));
    assign w_rem_mask = r_pstep - 8'd1;
    assign w_upd_now  = r_upd && r_pstep != 8'd0 && ((r_idx & w_rem_mask) == 8'd0);
    assign w_step  = w_upd_now ? r_pstep : r_astep;
    assign w_run   = (r_idx == 8'd0) ? r_armed : r_run;
    assign w_samp  = r_use_st ? r_st_rd : r_ps_rd;
    // finished tick moves to the result register once it is free or being popped
    assign w_out_move = (r_st == S_OUT) && (!r_outv || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_clr <= '0;
            r_idx <= '0; r_astep <= 8'd1; r_pstep <= 8'd1; r_cstep <= 8'd1;
            r_pper <= RESET_PERIOD; r_aper <= RESET_PERIOD;
            r_upd <= 1'b0; r_armed <= 1'b0; r_run <= 1'b0; r_outv <= 1'b0;
            r_last <= '0; r_log2 <= RESET_LOG2;
        end else begin
            if (i_cfg_we) r_log2 <= i_cfg_wdata;
            if (w_out_move) r_outv <= 1'b1;
            else if (i_pop && r_outv) r_outv <= 1'b0;
            case (r_st)
                S_CLR: begin
                    r_play[r_clr] <= 8'd0;
                    r_stage[r_clr] <= 8'd0;
                    r_clr <= r_clr + 8'd1;
                    if (r_clr == 8'(DEPTH_MASK)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_take) begin
                        r_it <= i_data;
                        case (i_data.func)
                            FUNC_STAGE: begin
                                if (!r_run) begin
                                    r_stage[i_data.entry_index] <= i_data.entry_value;
                                    if (i_data.entry_last) begin
                                        r_cstep <= r_pstep;
                                        r_armed <= 1'b1;
                                    end
                                end
                            end
                            FUNC_RATE: begin
                                if (i_data.step_rate != 24'd0 && i_data.step_rate != r_last) begin
                                    r_last <= i_data.step_rate;
                                    r_sh <= 3'd0;
                                    r_st <= S_DIV;
                                end
                            end
                            FUNC_TICK: begin
                                if (w_upd_now) begin
                                    r_aper <= r_pper;
                                    r_astep <= r_pstep;
                                    r_upd <= 1'b0;
                                end
                                if (r_idx == 8'd0) begin
                                    r_run <= r_armed;
                                    r_armed <= 1'b0;
                                end
                                r_use_st <= w_run;
                                r_ridx <= r_idx;
                                r_ps_rd <= r_play[r_idx];
                                r_st_rd <= r_stage[r_idx];
                                r_idx <= (r_idx + w_step) & w_mask;
                                r_st <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: r_st <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        r_q <= w_quo;
                        if (w_hit) begin
                            r_pstep <= 8'd1 << r_sh;
                            r_st <= S_RATE;
                        end else if (32'(r_sh) == N_SHIFTS - 1) begin
                            r_st <= S_RATE;
                        end else begin
                            r_sh <= r_sh + 3'd1;
                            r_st <= S_DIV;
                        end
                    end
                end
                S_RATE: begin
                    if (r_q == '0) r_pper <= 16'd0;
                    else if (r_q - DW'(1) > DW'(65535)) r_pper <= 16'hFFFF;
                    else r_pper <= 16'(r_q - DW'(1));
                    r_upd <= 1'b1;
                    if (r_pstep < r_cstep) begin
                        r_cstep <= r_pstep;
                        r_armed <= 1'b1;
                    end
                    r_st <= S_IDLE;
                end
                S_READ: begin
                    if (r_use_st) r_play[r_ridx] <= w_samp;
                    r_pend.pwm_level <= w_samp ^ 8'h80;
                    r_pend.timer_period <= r_aper;
                    r_pend.played_index <= r_ridx;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_move) begin
                        r_out <= r_pend;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `WPE_ASSERT(a_no_take_busy, i_clk, i_rst_n, o_take |=> r_st != S_IDLE || r_it.func != FUNC_TICK, "tick finished too early")
    `WPE_ASSERT(a_out_hold, i_clk, i_rst_n, (r_outv && !i_pop) |=> r_outv && $stable(r_out), "result lost")
    `WPE_ASSERT(a_idx_mask, i_clk, i_rst_n, (r_st == S_READ) |-> ((r_idx & ~w_mask) == 8'd0 || $past(i_cfg_we)), "index beyond mask")
    `WPE_ASSERT(a_step_pow2, i_clk, i_rst_n, 1'b1 |-> $onehot(r_pstep) && $onehot(r_astep), "step not power of two")
endmodule

FILE: rtl/core/wavetable_playback_engine.sv
// ----------------------------------------------------------------------------
// wavetable_playback_engine
// Double-buffered wavetable oscillator: input queue front, executing back.
// ----------------------------------------------------------------------------
// Timing: a tick beat passes from the queue through S_READ and S_OUT into the
// result register, and waits in S_OUT while that register is full. Stage beats
// are executed as they leave the queue. A rate beat runs up to eight serial
// divisions in the shared divider. The back takes no new beat until it is back in S_IDLE, so ticks do not overlap.
// Reset (synchronous, active low) clears control state, then a clearing pass
// over every entry zeroes both tables before the first beat is taken.
module wavetable_playback_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wpe_pkg::t_in_item  i_data,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output wpe_pkg::t_out_item o_data,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata
);
    import wpe_pkg::*;
    logic     w_valid, w_take;
    t_in_item w_item;

    // front: two-entry queue, unused func codes dropped on entry
    wpe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_data(i_data),
        .o_full(o_full), .o_valid(w_valid), .o_data(w_item), .i_take(w_take)
    );

    // back: tables, rate search, pending tick register, one-entry result register
    wpe_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_valid(w_valid), .i_data(w_item),
        .o_take(w_take), .o_empty(o_empty), .o_data(o_data), .i_pop(i_pop)
    );
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for wavetable_playback_engine. A directed table walks
// the ticks after reset, stage items, rate extremes and ignored items. Random
// phases then run under several table lengths. Every tick result is compared
// with its typed-in expectation or with an in-bench model of the playback state.
// ----------------------------------------------------------------------------
module testbench;
    import wpe_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 1000;  // covers three queued rate division runs
    localparam int ITEMS_PER_PHASE = 250;

    typedef struct {
        t_in_item  item;
        bit        known;   // expected result typed in below
        t_out_item result;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_push = 1'b0;
    t_in_item  i_data = '0;
    logic      o_full;
    logic      o_empty;
    logic      i_pop = 1'b0;
    t_out_item o_data;
    logic      i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = '0;

    wavetable_playback_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_data      (i_data),
        .o_full      (o_full),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Playback model: tables, index, step/period pipeline, copy control
    // ---------------------------------------------------------------------
    logic [7:0]  play_tab [256];
    logic [7:0]  stage_tab [256];
    logic [7:0]  play_pos;
    logic [7:0]  step_now, step_next, copy_stride;
    logic [15:0] period_now, period_next;
    bit          period_pending, copy_pending, copy_busy;
    logic [31:0] prev_rate;
    logic [3:0]  len_log2;

    t_out_item   pwm_expect_q[$];
    int          mismatches = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    bit          sender_quiet = 1'b0;

    function automatic logic [7:0] wrap_mask();
        int l;
        l = (len_log2 > 8) ? 8 : len_log2;
        return 8'(((1 << l) - 1) & (TABLE_DEPTH - 1));
    endfunction

    function automatic void model_reset();
        for (int k = 0; k < 256; k++) begin
            play_tab[k]  = '0;
            stage_tab[k] = '0;
        end
        play_pos = '0;
        step_now = 8'd1;
        step_next = 8'd1;
        copy_stride = 8'd1;
        period_now = RESET_PERIOD;
        period_next = RESET_PERIOD;
        period_pending = 0;
        copy_pending = 0;
        copy_busy = 0;
        prev_rate = '0;
        len_log2 = RESET_LOG2;
    endfunction

    // Rate change: smallest shift whose quotient exceeds 255 picks the step.
    function automatic void model_rate(logic [31:0] rate);
        longint unsigned q;
        q = 0;
        if (rate == 0 || rate == prev_rate) return;
        prev_rate = rate;
        for (int s = 0; s < N_SHIFTS; s++) begin
            q = (64'(CLOCK_HZ) << s) / rate;
            if (q > 255) begin
                step_next = 8'(1 << s);
                break;
            end
        end
        if (q == 0) period_next = '0;
        else if (q - 1 > 65535) period_next = 16'hFFFF;
        else period_next = 16'(q - 1);
        period_pending = 1;
        if (step_next < copy_stride) begin
            copy_stride = step_next;
            copy_pending = 1;
        end
    endfunction

    // Returns 1 when the beat produces a result.
    function automatic bit model_beat(t_in_item it, output t_out_item res);
        logic [7:0] pos, smp;
        res = '0;
        case (it.func)
            FUNC_STAGE: begin
                if (!copy_busy) begin
                    stage_tab[it.entry_index] = it.entry_value;
                    if (it.entry_last) begin
                        copy_stride = step_next;
                        copy_pending = 1;
                    end
                end
                return 0;
            end
            FUNC_RATE: begin
                model_rate({8'd0, it.step_rate});
                return 0;
            end
            FUNC_TICK: begin
                pos = play_pos;
                if (period_pending && step_next != 0 && (pos % step_next) == 0) begin
                    period_now = period_next;
                    step_now = step_next;
                    period_pending = 0;
                end
                if (pos == 0) begin
                    if (copy_pending) begin
                        copy_busy = 1;
                        copy_pending = 0;
                    end else if (copy_busy) begin
                        copy_busy = 0;
                    end
                end
                if (copy_busy) begin
                    smp = stage_tab[pos];
                    play_tab[pos] = smp;
                end else begin
                    smp = play_tab[pos];
                end
                res.pwm_level = smp ^ 8'h80;
                res.timer_period = period_now;
                res.played_index = pos;
                play_pos = (pos + step_now) & wrap_mask();
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic t_in_item mk(logic [1:0] f, logic [7:0] idx, logic [7:0] val,
                                    logic last, logic [23:0] rate);
        t_in_item it;
        it.func = f;
        it.entry_index = idx;
        it.entry_value = val;
        it.entry_last = last;
        it.step_rate = rate;
        return it;
    endfunction

    function automatic t_out_item res(logic [7:0] lvl, logic [15:0] per, logic [7:0] idx);
        t_out_item r;
        r.pwm_level = lvl;
        r.timer_period = per;
        r.played_index = idx;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Sender: one beat per call, random gaps, predicts at acceptance
    // ---------------------------------------------------------------------
    task automatic send_beat(t_in_item it, bit known, t_out_item typed);
        t_out_item p;
        while (!sender_quiet && !(beats_in >= 500 && beats_in < 700)
               && $urandom_range(99) < 9) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        beats_in++;
        if (model_beat(it, p)) pwm_expect_q.push_back(known ? typed : p);
    endtask

    function automatic t_in_item random_beat();
        int sel;
        logic [23:0] rate;
        sel = $urandom_range(99);
        if (sel < 3)
            return mk(FUNC_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom), 24'($urandom));
        if (sel < 60)
            return mk(FUNC_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 24'($urandom));
        if (sel < 88)
            return mk(FUNC_STAGE, 8'($urandom), 8'($urandom), ($urandom_range(15) == 0),
                      24'($urandom));
        // spread rates over decades so every shift and saturation shows up
        case ($urandom_range(4))
            0: rate = 24'($urandom_range(255, 1));
            1: rate = 24'($urandom_range(70000, 256));
            2: rate = 24'($urandom_range(2000000, 70000));
            3: rate = 24'($urandom);
            default: rate = 24'($urandom_range(4, 0));   // zero and repeats
        endcase
        return mk(FUNC_RATE, 8'($urandom), 8'($urandom), 1'($urandom), rate);
    endfunction

    // Register writes only with the engine drained and a rate run finished.
    task automatic write_length(logic [3:0] v);
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pwm_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        len_log2 = v;
    endtask

    // ---------------------------------------------------------------------
    // Receiver: random pops, one long hold-off to back the queue up
    // ---------------------------------------------------------------------
    int hold_left = 0;
    bit held_once = 0;

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && i_pop && !o_empty) begin
            beats_out++;
            if (pwm_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: lvl=%0d per=%0d idx=%0d",
                             o_data.pwm_level, o_data.timer_period, o_data.played_index);
            end else begin
                e = pwm_expect_q.pop_front();
                if (o_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp lvl=%0d per=%0d idx=%0d got lvl=%0d per=%0d idx=%0d",
                                 e.pwm_level, e.timer_period, e.played_index,
                                 o_data.pwm_level, o_data.timer_period, o_data.played_index);
                end
            end
        end
        if (!held_once && beats_out == 300) begin
            held_once <= 1'b1;
            hold_left <= 400;
            i_pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_pop <= 1'b0;
        end else if (beats_out >= 400 && beats_out < 600) begin
            i_pop <= 1'b1;
        end else begin
            i_pop <= ($urandom_range(99) >= 9);
        end
    end

    // Watchdog: cycles with no beat moving on either side
    int stuck = 0;
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty) || i_cfg_we) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    t_row directed[$];

    initial begin
        t_out_item none;
        logic [3:0] lengths[5];
        none = '0;
        lengths = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8};

        // after reset: zero tables play as mid-scale at the reset period
        directed.push_back('{mk(FUNC_TICK, 0, 0, 0, 0), 1, res(8'd128, 16'd1136, 8'd0)});
        directed.push_back('{mk(FUNC_TICK, 8'hFF, 8'hFF, 1, 24'hFFFFFF), 1,
                             res(8'd128, 16'd1136, 8'd1)});
        directed.push_back('{mk(FUNC_UNUSED, 8'hFF, 8'hFF, 1, 24'hFFFFFF), 0, none});
        directed.push_back('{mk(FUNC_STAGE, 8'd255, 8'h80, 0, 0), 0, none});
        directed.push_back('{mk(FUNC_STAGE, 8'd0, 8'h7F, 0, 0), 0, none});
        directed.push_back('{mk(FUNC_STAGE, 8'd1, 8'hFF, 1, 0), 0, none});
        directed.push_back('{mk(FUNC_RATE, 0, 0, 0, 24'd0), 0, none});       // zero rate
        directed.push_back('{mk(FUNC_RATE, 0, 0, 0, 24'd1), 0, none});       // saturates
        directed.push_back('{mk(FUNC_RATE, 0, 0, 0, 24'd1), 0, none});       // same rate
        directed.push_back('{mk(FUNC_TICK, 0, 0, 0, 0), 1, res(8'd128, 16'd65535, 8'd2)});
        directed.push_back('{mk(FUNC_RATE, 0, 0, 0, 24'hFFFFFF), 0, none});  // no shift fits
        directed.push_back('{mk(FUNC_TICK, 0, 0, 0, 0), 0, none});
        directed.push_back('{mk(FUNC_RATE, 0, 0, 0, 24'd16000000), 0, none});
        directed.push_back('{mk(FUNC_TICK, 0, 0, 0, 0), 0, none});
        directed.push_back('{mk(FUNC_RATE, 0, 0, 0, 24'd62500), 0, none});
        directed.push_back('{mk(FUNC_TICK, 0, 0, 0, 0), 0, none});
        directed.push_back('{mk(FUNC_RATE, 0, 0, 0, 24'd8000000), 0, none}); // step 128
        for (int k = 0; k < 8; k++)
            directed.push_back('{mk(FUNC_TICK, 0, 0, 0, 0), 0, none});

        model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_beat(directed[k].item, directed[k].known, directed[k].result);

        foreach (lengths[p]) begin
            write_length(lengths[p]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_beat(random_beat(), 0, none);
        end
        i_push <= 1'b0;

        while (pwm_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pwm_expect_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
